// ===== rtl/sshm_pkg.sv =====
package sshm_pkg;

    // stream layout
    localparam int CAMERA_STREAMS = 4;
    localparam int NSTREAMS       = CAMERA_STREAMS + 1;
    localparam int ADDR_W         = $clog2(NSTREAMS);

    // field widths
    localparam int IDX_W      = 3;
    localparam int SEQ_W      = 32;
    localparam int TS_W       = 63;
    localparam int CNT_W      = 32;
    localparam int GAP_W      = 48;
    localparam int PERIOD_W   = 32;
    localparam int FACTOR_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = PERIOD_W + FACTOR_W;
    localparam int THR_W      = PROD_W - FRAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // late factor of 1.0 in q8.8, also the floor for the factor
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1 << FRAC_W);
    // periods below this disable the late check
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_PERIOD = 2'd0,
        CFG_IMU_PERIOD    = 2'd1,
        CFG_LATE_FACTOR   = 2'd2
    } t_cfg_idx;

    // one memory row: per-stream history and counters
    typedef struct packed {
        logic [SEQ_W-1:0] last_seq;
        logic [TS_W-1:0]  last_stamp;
        logic [CNT_W-1:0] msg_cnt;
        logic [CNT_W-1:0] zero_cnt;
        logic [GAP_W-1:0] gap_total;
        logic [CNT_W-1:0] back_cnt;
        logic [CNT_W-1:0] late_cnt;
        logic [CNT_W-1:0] span_cnt;
        logic [TS_W-1:0]  span_total;
    } t_row;

    typedef struct packed {
        logic             first_message;
        logic [CNT_W-1:0] message_count;
        logic [CNT_W-1:0] zero_stamp_count;
        logic [GAP_W-1:0] sequence_gap_total;
        logic [CNT_W-1:0] non_monotonic_count;
        logic [CNT_W-1:0] late_count;
        logic [CNT_W-1:0] interval_tally;
        logic [TS_W-1:0]  interval_sum_ns;
        logic             late_now;
        logic             gap_now;
    } t_result;

endpackage

// ===== rtl/sshm_ifs.sv =====
interface sshm_cfg_if;
    import sshm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface sshm_in_if;
    import sshm_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] stream_index;
    logic [SEQ_W-1:0] sequence_req;
    logic [TS_W-1:0]  timestamp_ns;

    modport source (output valid, output stream_index, output sequence_req,
                    output timestamp_ns, input ready);
    modport sink   (input valid, input stream_index, input sequence_req,
                    input timestamp_ns, output ready);
endinterface

interface sshm_res_if;
    import sshm_pkg::*;

    logic             valid;
    logic             ready;
    logic             first_message;
    logic [CNT_W-1:0] message_count;
    logic [CNT_W-1:0] zero_stamp_count;
    logic [GAP_W-1:0] sequence_gap_total;
    logic [CNT_W-1:0] non_monotonic_count;
    logic [CNT_W-1:0] late_count;
    logic [CNT_W-1:0] interval_tally;
    logic [TS_W-1:0]  interval_sum_ns;
    logic             late_now;
    logic             gap_now;

    modport source (output valid, output first_message, output message_count,
                    output zero_stamp_count, output sequence_gap_total,
                    output non_monotonic_count, output late_count,
                    output interval_tally, output interval_sum_ns,
                    output late_now, output gap_now, input ready);
    modport sink   (input valid, input first_message, input message_count,
                    input zero_stamp_count, input sequence_gap_total,
                    input non_monotonic_count, input late_count,
                    input interval_tally, input interval_sum_ns,
                    input late_now, input gap_now, output ready);
endinterface

// ===== rtl/sensor_stream_health_monitor_core.sv =====
// path: an accepted beat passes the stage 1 and stage 2 registers into the output register
// throughput: one beat per cycle unless output stalls, set by the read-modify-write of the
//   per-stream row memory (read at accept, update in stage 2, write back with forwarding)
// reset: config returns to defaults (periods 0, factor 1.0), stream valid bits clear at
//   once so every stream starts fresh, pipeline and output empty; no memory sweep
module sensor_stream_health_monitor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sshm_cfg_if.sink    i_cfg,
    sshm_in_if.sink     i_in,
    sshm_res_if.source  o_res
);
    import sshm_pkg::*;

    // saturating helpers
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (&a) ? a : a + CNT_W'(1);
    endfunction

    function automatic logic [GAP_W-1:0] sat_add_gap(input logic [GAP_W-1:0] a,
                                                     input logic [SEQ_W-1:0] b);
        logic [GAP_W:0] s;
        s = {1'b0, a} + (GAP_W+1)'(b);
        return s[GAP_W] ? {GAP_W{1'b1}} : s[GAP_W-1:0];
    endfunction

    function automatic logic [TS_W-1:0] sat_add_ts(input logic [TS_W-1:0] a,
                                                   input logic [TS_W-1:0] b);
        logic [TS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TS_W] ? {TS_W{1'b1}} : s[TS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers and derived late thresholds
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0] r_cam_period;
    logic [PERIOD_W-1:0] r_imu_period;
    logic [FACTOR_W-1:0] r_factor;
    logic [THR_W-1:0]    r_cam_thr;
    logic [THR_W-1:0]    r_imu_thr;
    logic                r_cam_late_en;
    logic                r_imu_late_en;

    logic [FACTOR_W-1:0] factor_eff;
    logic [PROD_W-1:0]   cam_prod;
    logic [PROD_W-1:0]   imu_prod;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_period <= '0;
            r_imu_period <= '0;
            r_factor     <= FACTOR_ONE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CAMERA_PERIOD: r_cam_period <= i_cfg.data[PERIOD_W-1:0];
                CFG_IMU_PERIOD:    r_imu_period <= i_cfg.data[PERIOD_W-1:0];
                CFG_LATE_FACTOR:   r_factor     <= i_cfg.data[FACTOR_W-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // a factor below 1.0 acts as 1.0
    assign factor_eff = (r_factor < FACTOR_ONE) ? FACTOR_ONE : r_factor;
    assign cam_prod   = PROD_W'(factor_eff) * PROD_W'(r_cam_period);
    assign imu_prod   = PROD_W'(factor_eff) * PROD_W'(r_imu_period);

    // thresholds registered next cycle; user must change config only while idle, not enforced
    always_ff @(posedge i_clk) begin
        r_cam_thr     <= cam_prod[PROD_W-1:FRAC_W];
        r_imu_thr     <= imu_prod[PROD_W-1:FRAC_W];
        r_cam_late_en <= (r_cam_period >= PERIOD_MIN);
        r_imu_late_en <= (r_imu_period >= PERIOD_MIN);
    end

    // ------------------------------------------------------------------
    // pipeline control: all stages move together, stage 2 drains into
    // the output register whenever that register is free or being taken
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic advance;
    logic in_range;
    logic [ADDR_W-1:0] in_addr;
    logic wr_en;

    assign advance    = !r_s2_valid || !r_out_valid || o_res.ready;
    assign i_in.ready = advance;
    assign in_range   = (i_in.stream_index < IDX_W'(NSTREAMS));
    assign in_addr    = in_range ? i_in.stream_index[ADDR_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_s1_valid <= i_in.valid;
                r_s2_valid <= r_s1_valid;
            end
            if (advance && r_s2_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stream memory and valid bits
    // ------------------------------------------------------------------
    t_row              r_mem [NSTREAMS];
    logic [NSTREAMS-1:0] r_seen;

    // stage 1 registers
    logic              r_s1_inr;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [SEQ_W-1:0]  r_s1_seq;
    logic [TS_W-1:0]   r_s1_ts;
    logic              r_s1_seen;
    t_row              r_s1_row;

    // stage 2 registers
    logic              r_s2_inr;
    logic [ADDR_W-1:0] r_s2_addr;
    logic              r_s2_first;
    logic [SEQ_W-1:0]  r_s2_seq;
    logic [TS_W-1:0]   r_s2_ts;
    logic              r_s2_zero;
    logic              r_s2_gap_now;
    logic [SEQ_W-1:0]  r_s2_gap;
    logic              r_s2_nonmono;
    logic              r_s2_pos;
    logic [TS_W-1:0]   r_s2_interval;
    t_row              r_s2_row;

    t_row n_row;

    assign wr_en = r_s2_valid && r_s2_inr && advance;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s2_addr] <= n_row;
        end
        // read with write-through so a row written this edge is seen
        if (advance) begin
            if (wr_en && (r_s2_addr == in_addr)) begin
                r_s1_row <= n_row;
            end else begin
                r_s1_row <= r_mem[in_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (wr_en) begin
            r_seen[r_s2_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: forward from stage 2, compare against previous header
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_inr  <= in_range;
            r_s1_addr <= in_addr;
            r_s1_seq  <= i_in.sequence_req;
            r_s1_ts   <= i_in.timestamp_ns;
            r_s1_seen <= r_seen[in_addr] | (wr_en && (r_s2_addr == in_addr));
        end
    end

    logic             fwd;
    logic             seen;
    t_row             base;
    logic [SEQ_W-1:0] next_seq;
    logic             stamp_le;

    assign fwd      = r_s2_valid && r_s2_inr && (r_s2_addr == r_s1_addr);
    assign seen     = fwd || r_s1_seen;
    // a stream never written reads as all zeros
    assign base     = fwd ? n_row : (r_s1_seen ? r_s1_row : '0);
    assign next_seq = base.last_seq + SEQ_W'(1);
    assign stamp_le = (r_s1_ts <= base.last_stamp);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_inr      <= r_s1_inr;
            r_s2_addr     <= r_s1_addr;
            r_s2_first    <= !seen;
            r_s2_seq      <= r_s1_seq;
            r_s2_ts       <= r_s1_ts;
            r_s2_zero     <= (r_s1_ts == '0);
            r_s2_gap_now  <= seen && (r_s1_seq > next_seq);
            r_s2_gap      <= r_s1_seq - base.last_seq - SEQ_W'(1);
            r_s2_nonmono  <= seen && stamp_le;
            r_s2_pos      <= seen && !stamp_le;
            r_s2_interval <= r_s1_ts - base.last_stamp;
            r_s2_row      <= base;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: counter updates, write back and result
    // ------------------------------------------------------------------
    logic             is_imu;
    logic             late_en;
    logic [THR_W-1:0] late_thr;
    logic             late_now;

    assign is_imu   = (r_s2_addr == ADDR_W'(CAMERA_STREAMS));
    assign late_en  = is_imu ? r_imu_late_en : r_cam_late_en;
    assign late_thr = is_imu ? r_imu_thr : r_cam_thr;
    assign late_now = r_s2_pos && late_en && (r_s2_interval > TS_W'(late_thr));

    always_comb begin
        n_row            = r_s2_row;
        n_row.last_seq   = r_s2_seq;
        n_row.last_stamp = r_s2_ts;
        n_row.msg_cnt    = sat_inc(r_s2_row.msg_cnt);
        if (r_s2_zero) begin
            n_row.zero_cnt = sat_inc(r_s2_row.zero_cnt);
        end
        if (r_s2_gap_now) begin
            n_row.gap_total = sat_add_gap(r_s2_row.gap_total, r_s2_gap);
        end
        if (r_s2_nonmono) begin
            n_row.back_cnt = sat_inc(r_s2_row.back_cnt);
        end
        if (r_s2_pos) begin
            n_row.span_cnt   = sat_inc(r_s2_row.span_cnt);
            n_row.span_total = sat_add_ts(r_s2_row.span_total, r_s2_interval);
        end
        if (late_now) begin
            n_row.late_cnt = sat_inc(r_s2_row.late_cnt);
        end
    end

    t_result r_out;
    t_result n_out;

    // out-of-range streams give an all-zero result
    always_comb begin
        n_out = '0;
        if (r_s2_inr) begin
            n_out.first_message       = r_s2_first;
            n_out.message_count       = n_row.msg_cnt;
            n_out.zero_stamp_count    = n_row.zero_cnt;
            n_out.sequence_gap_total  = n_row.gap_total;
            n_out.non_monotonic_count = n_row.back_cnt;
            n_out.late_count          = n_row.late_cnt;
            n_out.interval_tally      = n_row.span_cnt;
            n_out.interval_sum_ns     = n_row.span_total;
            n_out.late_now            = late_now;
            n_out.gap_now             = r_s2_gap_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.first_message       = r_out.first_message;
    assign o_res.message_count       = r_out.message_count;
    assign o_res.zero_stamp_count    = r_out.zero_stamp_count;
    assign o_res.sequence_gap_total  = r_out.sequence_gap_total;
    assign o_res.non_monotonic_count = r_out.non_monotonic_count;
    assign o_res.late_count          = r_out.late_count;
    assign o_res.interval_tally      = r_out.interval_tally;
    assign o_res.interval_sum_ns     = r_out.interval_sum_ns;
    assign o_res.late_now            = r_out.late_now;
    assign o_res.gap_now             = r_out.gap_now;

endmodule
